>>> hdl/ceth_pkg.sv
// ----------------------------------------------------------------------------
// ceth_pkg: shared types and constants for the edge thinning pipeline
// Beat formats, configuration register codes, direction bins and the
// per-window arithmetic of the blur and suppression steps.
// ----------------------------------------------------------------------------
package ceth_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int PIXEL_W       = 8;
	localparam int ROW_W         = 13;
	localparam int MAX_HEIGHT    = 4096;
	localparam int WIDTH_REG_W   = 12;
	localparam int HEIGHT_REG_W  = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;
	localparam int MAG_W         = 21;
	localparam int BIN_W         = 2;
	localparam int GRAD_W        = MAG_W + BIN_W;
	localparam int SOBEL_W       = 11;
	localparam int TAN22_Q8      = 106;
	localparam int TAN67_Q8      = 618;
	localparam int OUT_ROW_W     = 12;
	localparam int OUT_COL_W     = 11;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [BIN_W-1:0] {
		BIN_HORZ    = 2'd0,
		BIN_DIAG_UR = 2'd1,
		BIN_VERT    = 2'd2,
		BIN_DIAG_UL = 2'd3
	} bin_t;

	typedef struct packed {
		logic               mode;
		logic [PIXEL_W-1:0] pixel;
	} src_beat_t;

	typedef struct packed {
		logic                 edge_res;
		logic [OUT_ROW_W-1:0] out_row;
		logic [OUT_COL_W-1:0] out_column;
		logic                 frame_end;
	} dst_beat_t;

	// 1-2-1 / 2-4-2 / 1-2-1 kernel, divided by 16 with truncation
	function automatic logic [PIXEL_W-1:0] blur_of(input logic [2:0][2:0][PIXEL_W-1:0] w);
		logic [PIXEL_W+3:0] corners;
		logic [PIXEL_W+3:0] edges;
		logic [PIXEL_W+3:0] sum;
		corners = (PIXEL_W+4)'(w[0][0]) + (PIXEL_W+4)'(w[0][2])
		        + (PIXEL_W+4)'(w[2][0]) + (PIXEL_W+4)'(w[2][2]);
		edges   = (PIXEL_W+4)'(w[0][1]) + (PIXEL_W+4)'(w[2][1])
		        + (PIXEL_W+4)'(w[1][0]) + (PIXEL_W+4)'(w[1][2]);
		sum     = corners + (edges << 1) + ((PIXEL_W+4)'(w[1][1]) << 2);
		return sum[PIXEL_W+3:4];
	endfunction

	// keep the center only if it beats both neighbors along its bin
	function automatic logic suppress_of(input logic [2:0][2:0][GRAD_W-1:0] w);
		logic [MAG_W-1:0] m;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
		m = w[1][1][MAG_W-1:0];
		case (bin_t'(w[1][1][GRAD_W-1:MAG_W]))
			BIN_HORZ: begin
				a = w[1][0][MAG_W-1:0];
				b = w[1][2][MAG_W-1:0];
			end
			BIN_DIAG_UR: begin
				a = w[0][2][MAG_W-1:0];
				b = w[2][0][MAG_W-1:0];
			end
			BIN_VERT: begin
				a = w[0][1][MAG_W-1:0];
				b = w[2][1][MAG_W-1:0];
			end
			default: begin
				a = w[0][0][MAG_W-1:0];
				b = w[2][2][MAG_W-1:0];
			end
		endcase
		return (m > a) && (m > b);
	endfunction

endpackage

>>> hdl/ceth_ram.sv
// ----------------------------------------------------------------------------
// ceth_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ceth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ceth_cell.sv
// ----------------------------------------------------------------------------
// ceth_cell: two-line buffer with a 3x3 window
// Each beat reads the two stored lines at its column, shifts the window
// left by one, and pushes the new sample into the line store.
// ----------------------------------------------------------------------------
module ceth_cell #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [$clog2(DEPTH)-1:0]       in_col,
	input  logic [DATA_W-1:0]              in_val,
	output logic [2:0][2:0][DATA_W-1:0]    win
);

	localparam int AW = $clog2(DEPTH);

	logic              a_vld_s;
	logic [AW-1:0]     a_col_s;
	logic [DATA_W-1:0] a_val_s;
	logic [2*DATA_W-1:0] rd;
	logic [2:0][2:0][DATA_W-1:0] win_q;

	assign win = win_q;

	// line store: upper half is the older line, lower half the newer one
	ceth_ram #(
		.WIDTH(2*DATA_W),
		.DEPTH(DEPTH)
	) u_lines (
		.clk  (clk),
		.we   (en & a_vld_s),
		.waddr(a_col_s),
		.wdata({rd[DATA_W-1:0], a_val_s}),
		.re   (en),
		.raddr(in_col),
		.rdata(rd)
	);

	// hold the beat while its line read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s <= 1'b0;
		end else if (en) begin
			a_vld_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_col_s <= in_col;
			a_val_s <= in_val;
		end
	end

	// shift the window and load the new right column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (en && a_vld_s) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd[2*DATA_W-1:DATA_W];
			win_q[1][2] <= rd[DATA_W-1:0];
			win_q[2][2] <= a_val_s;
		end
	end

endmodule

>>> hdl/canny_edge_thinning.sv
// ----------------------------------------------------------------------------
// canny_edge_thinning: blur, Sobel gradient and non-maximum suppression
// Three window cells in a row turn a raster pixel stream into a thinned
// binary edge map.
// ----------------------------------------------------------------------------
// Usage:
//   src channel takes one beat per pixel in raster order (mode 0) or a flush
//   beat (mode 1). dst channel returns one edge-map pixel with its row,
//   column and a frame_end mark on the last pixel of the frame.
//   Frame size comes from cfg writes (index 0 width, index 1 height); it is
//   sampled on the first beat of each frame and clamped to the legal range.
//   Each of the three cells delays the image by one row plus one pixel, so
//   the edge pixel for a source position appears 3*(W+1) beats later; push
//   3*(W+1) flush beats after the last pixel to drain a frame.
//   One beat is taken per clock unless dst stalls with a result held; the
//   rate is set by the line stores, one read and one write per cell per beat.
//   Reset returns the size registers to 640x480 and restarts frame counting;
//   line store contents need no clearing.
//   When dst stalls with a result held, the whole pipeline holds and src
//   sees stall in the same cycle.
// ----------------------------------------------------------------------------
module canny_edge_thinning #(
	parameter int MAX_WIDTH = ceth_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ceth_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  ceth_pkg::src_beat_t             src_beat,
	output logic                            dst_valid,
	input  logic                            dst_stall,
	output ceth_pkg::dst_beat_t             dst_beat
);

	import ceth_pkg::*;

	localparam int CAW = $clog2(MAX_WIDTH);
	localparam int CW  = $clog2(MAX_WIDTH + 1);

	typedef struct packed {
		logic                 vld;
		logic                 act1;
		logic                 act2;
		logic                 act3;
		logic [CAW-1:0]       col0;
		logic [CAW-1:0]       col1;
		logic [CAW-1:0]       col2;
		logic                 int1;
		logic                 int2;
		logic                 int3;
		logic [OUT_ROW_W-1:0] orow;
		logic [OUT_COL_W-1:0] ocol;
		logic                 fend;
	} ctrl_t;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    first_q;
	logic [CW-1:0]           fw_q;
	logic [ROW_W-1:0]        fh_q;
	logic [ROW_W-1:0]        row_q [4];
	logic [CAW-1:0]          col_q [4];
	logic [3:1]              act_q;

	logic [31:0]      width32;
	logic [31:0]      height32;
	logic [CW-1:0]    fw_cfg;
	logic [ROW_W-1:0] fh_cfg;
	logic [CW-1:0]    fw_now;
	logic [ROW_W-1:0] fh_now;
	logic [3:0]       act_now;
	logic [3:0]       last_col;
	logic [3:0]       interior;
	logic             frame_end;
	logic             en;
	logic             step;
	logic [PIXEL_W-1:0] v0;
	ctrl_t            t0_d;

	ctrl_t t0_s, c0a_s, c0w_s, b_s, c1a_s, c1w_s, g1_s, g2_s, c2a_s, c2w_s;
	logic [PIXEL_W-1:0]        v0_s;
	logic [PIXEL_W-1:0]        v1_s;
	logic signed [SOBEL_W-1:0] gx_s;
	logic signed [SOBEL_W-1:0] gy_s;
	logic [GRAD_W-1:0]         v2_s;
	logic                      dst_valid_q;
	dst_beat_t                 dst_beat_q;

	logic [2:0][2:0][PIXEL_W-1:0] win0;
	logic [2:0][2:0][PIXEL_W-1:0] win1;
	logic [2:0][2:0][GRAD_W-1:0]  win2;

	logic signed [SOBEL_W-1:0]   gx_d;
	logic signed [SOBEL_W-1:0]   gy_d;
	logic signed [2*SOBEL_W-1:0] sqx;
	logic signed [2*SOBEL_W-1:0] sqy;
	logic [2*SOBEL_W-1:0]        mag_sum;
	logic [SOBEL_W-1:0]          ax;
	logic signed [SOBEL_W-1:0]   ngy;
	logic signed [21:0]          t_q8;
	logic signed [21:0]          lim22;
	logic signed [21:0]          lim67;
	bin_t                        bin;

	// pipeline advances unless a held result is being stalled
	assign en        = !(dst_valid_q && dst_stall);
	assign src_stall = !en;
	assign step      = src_valid && en;
	assign dst_valid = dst_valid_q;
	assign dst_beat  = dst_beat_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(WIDTH_RST);
			height_q <= HEIGHT_REG_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the frame size and pick it up at the start of a frame
	always_comb begin
		width32  = 32'(width_q);
		height32 = 32'(height_q);
		if (width32 < 32'd3) begin
			fw_cfg = CW'(3);
		end else if (width32 > 32'(MAX_WIDTH)) begin
			fw_cfg = CW'(MAX_WIDTH);
		end else begin
			fw_cfg = CW'(width32);
		end
		if (height32 < 32'd3) begin
			fh_cfg = ROW_W'(3);
		end else if (height32 > 32'(MAX_HEIGHT)) begin
			fh_cfg = ROW_W'(MAX_HEIGHT);
		end else begin
			fh_cfg = ROW_W'(height32);
		end
		fw_now = first_q ? fw_cfg : fw_q;
		fh_now = first_q ? fh_cfg : fh_q;
	end

	// per-stage position flags for the current beat
	always_comb begin
		act_now[0] = 1'b1;
		for (int k = 1; k < 4; k++) begin
			act_now[k] = act_q[k] || (act_now[k-1] && row_q[k-1] == ROW_W'(1)
			             && col_q[k-1] == CAW'(1));
		end
		for (int k = 0; k < 4; k++) begin
			last_col[k] = CW'(col_q[k]) == fw_now - CW'(1);
			interior[k] = (row_q[k] != '0)
			           && ((ROW_W+1)'(row_q[k]) + (ROW_W+1)'(2) <= (ROW_W+1)'(fh_now))
			           && (col_q[k] != '0)
			           && ((CW+1)'(col_q[k]) + (CW+1)'(2) <= (CW+1)'(fw_now));
		end
		frame_end = act_now[3] && last_col[3] && row_q[3] == fh_now - ROW_W'(1);
		v0 = (row_q[0] < fh_now && !src_beat.mode) ? src_beat.pixel : '0;
	end

	always_comb begin
		t0_d.vld  = step;
		t0_d.act1 = act_now[1];
		t0_d.act2 = act_now[2];
		t0_d.act3 = act_now[3];
		t0_d.col0 = col_q[0];
		t0_d.col1 = col_q[1];
		t0_d.col2 = col_q[2];
		t0_d.int1 = interior[1];
		t0_d.int2 = interior[2];
		t0_d.int3 = interior[3];
		t0_d.orow = row_q[3][OUT_ROW_W-1:0];
		t0_d.ocol = OUT_COL_W'(col_q[3]);
		t0_d.fend = frame_end;
	end

	// advance the position counters on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			fw_q    <= CW'(3);
			fh_q    <= ROW_W'(3);
			act_q   <= '0;
			for (int k = 0; k < 4; k++) begin
				row_q[k] <= '0;
				col_q[k] <= '0;
			end
		end else if (step) begin
			first_q <= frame_end;
			fw_q    <= fw_now;
			fh_q    <= fh_now;
			for (int k = 1; k < 4; k++) begin
				act_q[k] <= act_now[k] && !frame_end;
			end
			for (int k = 0; k < 4; k++) begin
				if (frame_end) begin
					row_q[k] <= '0;
					col_q[k] <= '0;
				end else if (act_now[k]) begin
					if (last_col[k]) begin
						col_q[k] <= '0;
						row_q[k] <= row_q[k] + ROW_W'(1);
					end else begin
						col_q[k] <= col_q[k] + CAW'(1);
					end
				end
			end
		end
	end

	// control beat pipeline, aligned with the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_s        <= '0;
			c0a_s       <= '0;
			c0w_s       <= '0;
			b_s         <= '0;
			c1a_s       <= '0;
			c1w_s       <= '0;
			g1_s        <= '0;
			g2_s        <= '0;
			c2a_s       <= '0;
			c2w_s       <= '0;
			dst_valid_q <= 1'b0;
		end else if (en) begin
			t0_s        <= t0_d;
			c0a_s       <= t0_s;
			c0w_s       <= c0a_s;
			b_s         <= c0w_s;
			c1a_s       <= b_s;
			c1w_s       <= c1a_s;
			g1_s        <= c1w_s;
			g2_s        <= g1_s;
			c2a_s       <= g2_s;
			c2w_s       <= c2a_s;
			dst_valid_q <= c2w_s.vld && c2w_s.act3;
		end
	end

	// Sobel components of the blurred window
	always_comb begin
		gx_d = SOBEL_W'(win1[0][2]) - SOBEL_W'(win1[0][0])
		     + (SOBEL_W'(win1[1][2]) << 1) - (SOBEL_W'(win1[1][0]) << 1)
		     + SOBEL_W'(win1[2][2]) - SOBEL_W'(win1[2][0]);
		gy_d = SOBEL_W'(win1[0][0]) + (SOBEL_W'(win1[0][1]) << 1) + SOBEL_W'(win1[0][2])
		     - SOBEL_W'(win1[2][0]) - (SOBEL_W'(win1[2][1]) << 1) - SOBEL_W'(win1[2][2]);
	end

	// squared magnitude and direction bin from Q8 ratio compares
	always_comb begin
		sqx     = gx_s * gx_s;
		sqy     = gy_s * gy_s;
		mag_sum = 22'(sqx) + 22'(sqy);
		ax      = gx_s[SOBEL_W-1] ? SOBEL_W'(-gx_s) : SOBEL_W'(gx_s);
		ngy     = gx_s[SOBEL_W-1] ? -gy_s : gy_s;
		t_q8    = 22'(ngy) <<< 8;
		lim22   = $signed(22'(ax) * 22'(TAN22_Q8));
		lim67   = $signed(22'(ax) * 22'(TAN67_Q8));
		if (gx_s == '0) begin
			bin = BIN_VERT;
		end else if (t_q8 < -lim67) begin
			bin = BIN_HORZ;
		end else if (t_q8 < -lim22) begin
			bin = BIN_DIAG_UR;
		end else if (t_q8 < lim22) begin
			bin = BIN_VERT;
		end else begin
			bin = BIN_DIAG_UL;
		end
	end

	// payload stages between the cells
	always_ff @(posedge clk) begin
		if (en) begin
			v0_s <= v0;
			v1_s <= c0w_s.int1 ? blur_of(win0) : '0;
			gx_s <= gx_d;
			gy_s <= gy_d;
			v2_s <= g1_s.int2 ? {bin, mag_sum[MAG_W-1:0]} : '0;
			dst_beat_q.edge_res   <= c2w_s.int3 && suppress_of(win2);
			dst_beat_q.out_row    <= c2w_s.orow;
			dst_beat_q.out_column <= c2w_s.ocol;
			dst_beat_q.frame_end  <= c2w_s.fend;
		end
	end

	// raw pixel cell
	ceth_cell #(
		.DATA_W(PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_cell_raw (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_vld(t0_s.vld),
		.in_col(t0_s.col0),
		.in_val(v0_s),
		.win   (win0)
	);

	// blurred pixel cell
	ceth_cell #(
		.DATA_W(PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_cell_blur (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_vld(b_s.vld && b_s.act1),
		.in_col(b_s.col1),
		.in_val(v1_s),
		.win   (win1)
	);

	// gradient cell: bin over squared magnitude
	ceth_cell #(
		.DATA_W(GRAD_W),
		.DEPTH (MAX_WIDTH)
	) u_cell_grad (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_vld(g2_s.vld && g2_s.act2),
		.in_col(g2_s.col2),
		.in_val(v2_s),
		.win   (win2)
	);

endmodule
